/* hw/rtl/rht_pkg.sv */
// Shared types and constants of the reference-count hash table.
// Depends on nothing; imported by every module of the block but rht_ram.
`timescale 1ns / 1ps

package rht_pkg;

   localparam int TABLE_SIZE  = 1024;              // power of two
   localparam int PROBE_LIMIT = 128;
   localparam int IDX_W       = $clog2(TABLE_SIZE);
   localparam int PROBE_W     = $clog2(PROBE_LIMIT + 1);
   localparam int LIVE_W      = 11;
   localparam int KEY_W       = 40;
   localparam int CNT_W       = 24;
   localparam int WORD_W      = KEY_W + CNT_W;
   localparam int HASH_BYTES  = 8;
   localparam int STEP_W      = $clog2(HASH_BYTES);

   localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
   localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;

   localparam logic signed [CNT_W-1:0] COUNT_MAX = 24'sh7fffff;
   localparam logic signed [CNT_W-1:0] COUNT_MIN = 24'sh800000;
   localparam logic [WORD_W-1:0] TOMB_WORD = {{CNT_W{1'b0}}, {KEY_W{1'b1}}};

   typedef enum logic {
      OP_INC = 1'b0,
      OP_DEC = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STS_INSERTED  = 2'd0,
      STS_UPDATED   = 2'd1,
      STS_SATURATED = 2'd2,
      STS_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_PROBE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic             done;
      logic [IDX_W-1:0] idx;
   } hash_out_type;

   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  waddr;
      logic [WORD_W-1:0] wdata;
      logic              re;
      logic [IDX_W-1:0]  raddr;
   } mem_req_type;

endpackage

/* hw/rtl/refcount_hash_table.sv */
// Reference-count hash table, top level: table RAM, hash unit, probe controller.
// Each item passes through accept, key hashing, a linear probe over up to 128
// buckets and a finish step before rsp_valid; the probe stops at a match or an
// empty bucket, or when the whole window is searched. A new item is taken only
// after the previous response is registered. The probe does one table read per bucket.
// Reset (synchronous) starts a clearing pass over every bucket; req_ready is low
// until it ends.
`timescale 1ns / 1ps

module refcount_hash_table
   import rht_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_operation,
   input  logic [KEY_W-1:0]        req_key,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_status,
   output logic signed [CNT_W-1:0] rsp_new_count,
   output logic [LIVE_W-1:0]       rsp_unique_entries
);

   logic              hash_start;
   logic [KEY_W-1:0]  hash_key;
   hash_out_type      hash_out;
   mem_req_type       mem_req;
   logic [WORD_W-1:0] mem_rd_data;

   rht_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_SIZE)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_req.we),
      .wr_addr (mem_req.waddr),
      .wr_data (mem_req.wdata),
      .rd_en   (mem_req.re),
      .rd_addr (mem_req.raddr),
      .rd_data (mem_rd_data)
   );

   rht_hash u_hash (
      .clock    (clock),
      .reset    (reset),
      .start    (hash_start),
      .key      (hash_key),
      .hash_out (hash_out)
   );

   rht_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_key            (req_key),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_new_count      (rsp_new_count),
      .rsp_unique_entries (rsp_unique_entries),
      .hash_start         (hash_start),
      .hash_key           (hash_key),
      .hash_out           (hash_out),
      .mem_req            (mem_req),
      .mem_rd_data        (mem_rd_data)
   );

   // a fresh insert always starts at +1 or -1
   a_insert_unit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STS_INSERTED) |->
         (rsp_new_count == 24'sd1) || (rsp_new_count == -24'sd1))
      else $error("insert with count other than +1/-1");

   // a full table changes nothing and reports zero
   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STS_FULL) |-> (rsp_new_count == '0))
      else $error("full status with nonzero count");

   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_unique_entries <= LIVE_W'(TABLE_SIZE)))
      else $error("live entry count beyond table size");

   // an accepted item keeps the block busy while its key is hashed
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while previous one in flight");

endmodule

/* hw/rtl/rht_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// No package dependency.
`timescale 1ns / 1ps

module rht_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/rht_hash.sv */
// Iterative FNV-1a hash unit, one byte per cycle, eight bytes per key.
// Only the bucket index bits are kept: the low bits of a product depend
// only on the low bits of its operands. Depends on rht_pkg.
`timescale 1ns / 1ps

module rht_hash
   import rht_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [KEY_W-1:0] key,
   output hash_out_type     hash_out
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [IDX_W-1:0]  h_ff, h_in;
   logic [KEY_W-1:0]  key_ff, key_in;

   logic [63:0]        key64;
   logic [7:0]         cur_byte;
   logic [IDX_W-1:0]   h_x;
   logic [2*IDX_W-1:0] prod;

   always_comb begin
      key64    = {{(64 - KEY_W){1'b0}}, key_ff};
      cur_byte = key64[{step_ff, 3'b000} +: 8];
      h_x      = h_ff ^ IDX_W'(cur_byte);
      prod     = (2*IDX_W)'(h_x) * (2*IDX_W)'(FNV_PRIME[IDX_W-1:0]);

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      h_in    = h_ff;
      key_in  = key_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         h_in    = FNV_BASIS[IDX_W-1:0];
         key_in  = key;
      end else if (busy_ff) begin
         h_in    = prod[IDX_W-1:0];
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(HASH_BYTES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      h_ff   <= h_in;
      key_ff <= key_in;
   end

   assign hash_out.done = done_ff;
   assign hash_out.idx  = h_ff;

endmodule

/* hw/rtl/rht_ctrl.sv */
// Probe controller: clear sweep, linear probe over the table memory,
// read-modify-write of the chosen bucket, live count and result register.
// Depends on rht_pkg; drives the table RAM and the hash unit.
`timescale 1ns / 1ps

module rht_ctrl
   import rht_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_operation,
   input  logic [KEY_W-1:0]        req_key,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_status,
   output logic signed [CNT_W-1:0] rsp_new_count,
   output logic [LIVE_W-1:0]       rsp_unique_entries,
   output logic                    hash_start,
   output logic [KEY_W-1:0]        hash_key,
   input  hash_out_type            hash_out,
   output mem_req_type             mem_req,
   input  logic [WORD_W-1:0]       mem_rd_data
);

   state_type state_ff, state_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;
   logic               op_ff, op_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [IDX_W-1:0]   issue_idx_ff, issue_idx_in;
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   logic [PROBE_W-1:0] issued_ff, issued_in;
   logic               rd_pend_ff, rd_pend_in;
   logic               have_tomb_ff, have_tomb_in;
   logic [IDX_W-1:0]   tomb_idx_ff, tomb_idx_in;
   logic [LIVE_W-1:0]  live_ff, live_in;
   status_type         res_status_ff, res_status_in;
   logic signed [CNT_W-1:0] res_count_ff, res_count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic signed [CNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [LIVE_W-1:0]  rsp_uniq_ff, rsp_uniq_in;

   logic signed [CNT_W-1:0] w_cnt, dir, new_cnt;
   logic [KEY_W-1:0]   w_key;
   logic               is_empty, is_tomb, is_hit, exhausted, finish, sat;
   logic [WORD_W-1:0]  ins_word;

   always_comb begin
      w_cnt    = mem_rd_data[WORD_W-1:KEY_W];
      w_key    = mem_rd_data[KEY_W-1:0];
      dir      = (op_ff == OP_DEC) ? -24'sd1 : 24'sd1;
      new_cnt  = w_cnt + dir;
      ins_word = {dir, key_ff};
      is_empty = (mem_rd_data == '0);
      is_tomb  = !is_empty && (w_cnt == '0);
      is_hit   = !is_empty && !is_tomb && (w_key == key_ff);
      sat      = ((op_ff == OP_INC) && (w_cnt == COUNT_MAX)) ||
                 ((op_ff == OP_DEC) && (w_cnt == COUNT_MIN));
      // window done: nothing pending and every bucket already looked at
      exhausted = !rd_pend_ff && (issued_ff == PROBE_W'(PROBE_LIMIT));
      finish    = (rd_pend_ff && (is_empty || is_hit)) || exhausted;

      state_in      = state_ff;
      clr_in        = clr_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      issue_idx_in  = issue_idx_ff;
      chk_idx_in    = chk_idx_ff;
      issued_in     = issued_ff;
      rd_pend_in    = 1'b0;
      have_tomb_in  = have_tomb_ff;
      tomb_idx_in   = tomb_idx_ff;
      live_in       = live_ff;
      res_status_in = res_status_ff;
      res_count_in  = res_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_uniq_in   = rsp_uniq_ff;

      req_ready  = 1'b0;
      hash_start = 1'b0;
      hash_key   = req_key;
      mem_req    = '0;

      case (state_ff)
         ST_CLEAR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = clr_ff;
            mem_req.wdata = '0;
            clr_in        = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(TABLE_SIZE - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               hash_start = 1'b1;
               op_in      = req_operation;
               key_in     = req_key;
               state_in   = ST_HASH;
            end
         end
         ST_HASH: begin
            if (hash_out.done) begin
               issue_idx_in = hash_out.idx;
               issued_in    = '0;
               have_tomb_in = 1'b0;
               state_in     = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (rd_pend_ff && is_tomb && !have_tomb_ff) begin
               have_tomb_in = 1'b1;
               tomb_idx_in  = chk_idx_ff;
            end
            // one read in flight per cycle; data arrives for chk_idx next cycle
            if (!finish && (issued_ff != PROBE_W'(PROBE_LIMIT))) begin
               mem_req.re   = 1'b1;
               mem_req.raddr = issue_idx_ff;
               chk_idx_in   = issue_idx_ff;
               issue_idx_in = issue_idx_ff + IDX_W'(1);
               issued_in    = issued_ff + PROBE_W'(1);
               rd_pend_in   = 1'b1;
            end
            if (finish) begin
               state_in = ST_FINISH;
               if (exhausted) begin
                  if (have_tomb_ff) begin
                     mem_req.we    = 1'b1;
                     mem_req.waddr = tomb_idx_ff;
                     mem_req.wdata = ins_word;
                     live_in       = live_ff + LIVE_W'(1);
                     res_status_in = STS_INSERTED;
                     res_count_in  = dir;
                  end else begin
                     res_status_in = STS_FULL;
                     res_count_in  = '0;
                  end
               end else if (is_empty) begin
                  mem_req.we    = 1'b1;
                  mem_req.waddr = have_tomb_ff ? tomb_idx_ff : chk_idx_ff;
                  mem_req.wdata = ins_word;
                  live_in       = live_ff + LIVE_W'(1);
                  res_status_in = STS_INSERTED;
                  res_count_in  = dir;
               end else if (sat) begin
                  res_status_in = STS_SATURATED;
                  res_count_in  = w_cnt;
               end else begin
                  mem_req.we    = 1'b1;
                  mem_req.waddr = chk_idx_ff;
                  res_status_in = STS_UPDATED;
                  res_count_in  = new_cnt;
                  if (new_cnt == '0) begin
                     mem_req.wdata = TOMB_WORD;
                     if (live_ff != '0) begin
                        live_in = live_ff - LIVE_W'(1);
                     end
                  end else begin
                     mem_req.wdata = {new_cnt, key_ff};
                  end
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_count_in  = res_count_ff;
               rsp_uniq_in   = live_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rd_pend_ff   <= rd_pend_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      issue_idx_ff  <= issue_idx_in;
      chk_idx_ff    <= chk_idx_in;
      issued_ff     <= issued_in;
      have_tomb_ff  <= have_tomb_in;
      tomb_idx_ff   <= tomb_idx_in;
      res_status_ff <= res_status_in;
      res_count_ff  <= res_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_uniq_ff   <= rsp_uniq_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_new_count      = rsp_count_ff;
   assign rsp_unique_entries = rsp_uniq_ff;

endmodule
